// ===== rtl/etf_pkg.sv =====
`timescale 1ns / 1ps
package etf_pkg;
   localparam int FracBits = 26;
   localparam int MaxIter  = 256;
   localparam int CntW     = 9;
   localparam int IterW    = $clog2(MaxIter + 1);

   localparam logic [2:0] RegXStart = 3'd0;
   localparam logic [2:0] RegXStep  = 3'd1;
   localparam logic [2:0] RegYStart = 3'd2;
   localparam logic [2:0] RegYStep  = 3'd3;
   localparam logic [2:0] RegCRe    = 3'd4;
   localparam logic [2:0] RegCIm    = 3'd5;
   localparam logic [2:0] RegMode   = 3'd6;

   localparam logic signed [31:0] SatMax = 32'sh7fffffff;
   localparam logic signed [31:0] SatMin = -32'sh80000000;
   localparam logic [37:0] EscLimit = 38'd4 << FracBits;

   typedef enum logic [1:0] {ST_IDLE, ST_MAP, ST_RUN, ST_DONE} state_type;

   // token moving along the cell row
   typedef struct packed {
      logic        vld;
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic signed [31:0] cre;
      logic signed [31:0] cim;
      logic [IterW-1:0]   cnt;
      logic               fin;
   } tok_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'(SatMax)) return SatMax;
      if (v < 66'(SatMin)) return SatMin;
      return v[31:0];
   endfunction
endpackage

// ===== rtl/etf_sq_cell.sv =====
`timescale 1ns / 1ps
// stage 1 of the iteration: three products, registered
module etf_sq_cell (
   input  logic              clock,
   input  logic              reset,
   input  etf_pkg::tok_type  tok_i,
   output etf_pkg::tok_type  tok_o,
   output logic signed [63:0] rr_o,
   output logic signed [63:0] ii_o,
   output logic signed [63:0] ri_o
);
   import etf_pkg::*;
   tok_type tok_ff;
   logic signed [63:0] rr_ff, ii_ff, ri_ff;
   always_ff @(posedge clock) begin
      if (reset) tok_ff.vld <= 1'b0;
      else tok_ff.vld <= tok_i.vld;
      tok_ff.re <= tok_i.re; tok_ff.im <= tok_i.im;
      tok_ff.cre <= tok_i.cre; tok_ff.cim <= tok_i.cim;
      tok_ff.cnt <= tok_i.cnt; tok_ff.fin <= tok_i.fin;
      rr_ff <= 64'(tok_i.re) * 64'(tok_i.re);
      ii_ff <= 64'(tok_i.im) * 64'(tok_i.im);
      ri_ff <= 64'(tok_i.re) * 64'(tok_i.im);
   end
   assign tok_o = tok_ff;
   assign rr_o = rr_ff;
   assign ii_o = ii_ff;
   assign ri_o = ri_ff;
endmodule

// ===== rtl/etf_acc_cell.sv =====
`timescale 1ns / 1ps
// stage 2: escape test and z update
module etf_acc_cell (
   input  logic              clock,
   input  logic              reset,
   input  etf_pkg::tok_type  tok_i,
   input  logic signed [63:0] rr_i,
   input  logic signed [63:0] ii_i,
   input  logic signed [63:0] ri_i,
   output etf_pkg::tok_type  tok_o
);
   import etf_pkg::*;
   tok_type tok_ff, tok_in;
   logic [64:0] mag;
   logic [37:0] mag_s;
   logic signed [65:0] nre, nim;
   always_comb begin
      mag   = {1'b0, rr_i} + {1'b0, ii_i};
      mag_s = mag[FracBits +: 38];
      nre = 66'(rr_i >>> FracBits) - 66'(ii_i >>> FracBits) + 66'(tok_i.cre);
      nim = 66'(ri_i >>> (FracBits - 1)) + 66'(tok_i.cim);
      tok_in = tok_i;
      if (tok_i.vld && !tok_i.fin) begin
         if (tok_i.cnt >= IterW'(MaxIter) || mag_s > EscLimit) begin
            tok_in.fin = 1'b1;
         end else begin
            tok_in.re  = sat32(nre);
            tok_in.im  = sat32(nim);
            tok_in.cnt = tok_i.cnt + IterW'(1);
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) tok_ff.vld <= 1'b0;
      else tok_ff.vld <= tok_in.vld;
      tok_ff.re <= tok_in.re; tok_ff.im <= tok_in.im;
      tok_ff.cre <= tok_in.cre; tok_ff.cim <= tok_in.cim;
      tok_ff.cnt <= tok_in.cnt; tok_ff.fin <= tok_in.fin;
   end
   assign tok_o = tok_ff;
endmodule

// ===== rtl/escape_time_fractal_pixel.sv =====
`timescale 1ns / 1ps
// Escape-time fractal pixel engine. Each req item (pixel_x, pixel_y) is mapped
// to z0 = (x_start + pixel_x*x_step) + i(y_start + pixel_y*y_step), then
// z = z*z + c is iterated (c = z0 in Mandelbrot mode, the julia_c registers in
// Julia mode) until |z|^2 > 4 or MAX_ITER iterations; the count is the rsp
// item. One item is in flight at a time. For n iterations, after the req item
// is accepted the point is mapped in ST_MAP, then n+1 passes go around a row
// of two cells (multiply cell, then accumulate/test cell) which loops back,
// the last pass being the escape or limit test. A new item is accepted only
// once the result has been taken and the engine is idle again.
// Write csr_ only while idle.
module escape_time_fractal_pixel (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [9:0]  req_pixel_x,
   input  logic [9:0]  req_pixel_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [8:0]  rsp_iteration_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import etf_pkg::*;

   logic signed [31:0] xs_ff, xd_ff, ys_ff, yd_ff, cr_ff, ci_ff;
   logic mode_ff;
   state_type st_ff, st_in;
   logic signed [43:0] mx_ff, my_ff;
   logic [CntW-1:0] cnt_ff;
   tok_type seed, loop_tok, mid_tok, out_tok;
   logic signed [63:0] rr, ii, ri;
   logic signed [31:0] zr, zi;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         xs_ff <= -32'sd134217728; xd_ff <= 32'sd262144;
         ys_ff <= -32'sd134217728; yd_ff <= 32'sd262144;
         cr_ff <= '0; ci_ff <= '0; mode_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            RegXStart: xs_ff <= csr_data;
            RegXStep:  xd_ff <= csr_data;
            RegYStart: ys_ff <= csr_data;
            RegYStep:  yd_ff <= csr_data;
            RegCRe:    cr_ff <= csr_data;
            RegCIm:    ci_ff <= csr_data;
            RegMode:   mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (req_valid) st_in = ST_MAP;
         ST_MAP:  st_in = ST_RUN;
         ST_RUN:  if (out_tok.vld && out_tok.fin) st_in = ST_DONE;
         ST_DONE: if (rsp_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end
   // outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (st_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_DONE: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
      // pixel*step products registered at accept, added during ST_MAP
      if (req_valid && req_ready) begin
         mx_ff <= 44'($signed({1'b0, req_pixel_x})) * 44'(xd_ff);
         my_ff <= 44'($signed({1'b0, req_pixel_y})) * 44'(yd_ff);
      end
      if (st_ff == ST_RUN && out_tok.vld && out_tok.fin) cnt_ff <= out_tok.cnt[CntW-1:0];
   end

   assign zr = sat32(66'(mx_ff) + 66'(xs_ff));
   assign zi = sat32(66'(my_ff) + 66'(ys_ff));

   always_comb begin
      seed.vld = (st_ff == ST_MAP);
      seed.re  = zr;
      seed.im  = zi;
      seed.cre = mode_ff ? cr_ff : zr;
      seed.cim = mode_ff ? ci_ff : zi;
      seed.cnt = '0;
      seed.fin = 1'b0;
      loop_tok = out_tok;
      if (seed.vld) loop_tok = seed;
      else if (out_tok.fin || st_ff != ST_RUN) loop_tok.vld = 1'b0;
   end

   etf_sq_cell u_sq (
      .clock(clock), .reset(reset), .tok_i(loop_tok), .tok_o(mid_tok),
      .rr_o(rr), .ii_o(ii), .ri_o(ri)
   );
   etf_acc_cell u_acc (
      .clock(clock), .reset(reset), .tok_i(mid_tok),
      .rr_i(rr), .ii_i(ii), .ri_i(ri), .tok_o(out_tok)
   );

   assign rsp_iteration_count = cnt_ff;
endmodule

// ===== test/tb_escape_time_fractal_pixel.sv =====
`timescale 1ns / 1ps
module tb_escape_time_fractal_pixel;
   import etf_pkg::*;

   // iteration cap of the block; counts run 0..MaxIter
   localparam int ITER_CAP = 256;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [9:0]  req_pixel_x = '0;
   logic [9:0]  req_pixel_y = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [8:0]  rsp_iteration_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   escape_time_fractal_pixel dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_iteration_count(rsp_iteration_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the view registers
   logic signed [31:0] view_x0, view_dx, view_y0, view_dy, jc_re, jc_im;
   logic               mode_julia;

   int unsigned expected_counts[$];
   int          error_count = 0;
   bit          hold_rsp = 1'b0;   // forces a long receiver stall when set

   // clamp an exact value into the signed 32-bit range
   function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // |z|^2 in Q40.26, truncated
   function automatic logic [65:0] magsq(input logic signed [31:0] re,
                                         input logic signed [31:0] im);
      logic signed [65:0] s;
      s = 66'(re) * 66'(re) + 66'(im) * 66'(im);
      return s >>> FracBits;
   endfunction

   // escape count of one pixel under the current view
   function automatic int unsigned escape_count(input logic [9:0] px,
                                                input logic [9:0] py);
      logic signed [31:0] re, im, cre, cim;
      logic signed [65:0] rr, ii, ri;
      int unsigned n;
      re = clamp32(66'(view_x0) + 66'(signed'({1'b0, px})) * 66'(view_dx));
      im = clamp32(66'(view_y0) + 66'(signed'({1'b0, py})) * 66'(view_dy));
      cre = mode_julia ? jc_re : re;
      cim = mode_julia ? jc_im : im;
      n = 0;
      // >>> on a signed vector is an arithmetic shift, i.e. floor division
      while (n < ITER_CAP && magsq(re, im) <= (66'd4 << FracBits)) begin
         rr = (66'(re) * 66'(re)) >>> FracBits;
         ii = (66'(im) * 66'(im)) >>> FracBits;
         ri = (66'(re) * 66'(im)) >>> (FracBits - 1);
         re = clamp32(rr - ii + 66'(cre));
         im = clamp32(ri + 66'(cim));
         n++;
      end
      return n & 9'h1ff;
   endfunction

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      repeat (n) @(posedge clock);
   endtask

   // offer one pixel item and hold it until accepted
   task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
      req_valid   <= 1'b1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_counts.push_back(escape_count(px, py));
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         RegXStart: view_x0 = val;
         RegXStep:  view_dx = val;
         RegYStart: view_y0 = val;
         RegYStep:  view_dy = val;
         RegCRe:    jc_re = val;
         RegCIm:    jc_im = val;
         RegMode:   mode_julia = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // wait until every pending count has come back, then let the engine settle
   task automatic drain();
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_view(input logic [31:0] x0, dx, y0, dy);
      drain();
      write_reg(RegXStart, x0);
      write_reg(RegXStep, dx);
      write_reg(RegYStart, y0);
      write_reg(RegYStep, dy);
   endtask

   task automatic set_julia(input bit on, input logic [31:0] cr, ci);
      drain();
      write_reg(RegCRe, cr);
      write_reg(RegCIm, ci);
      write_reg(RegMode, {31'd0, on});
   endtask

   // corners, edges and center of the default view, mandelbrot mode
   task automatic test_directed_mandel();
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd512, 10'd512);   // origin: runs to the cap
      send_pixel(10'd256, 10'd512);   // -1.0: periodic, runs to the cap
      send_pixel(10'd384, 10'd640);
      send_pixel(10'h2aa, 10'h155);
      send_pixel(10'h155, 10'h2aa);
      // exactly |z|^2 == 4 does not escape at the start
      set_view(32'hf800_0000, 32'd0, 32'd0, 32'd0);
      send_pixel(10'd0, 10'd0);
   endtask

   // saturation of the point mapping and of the squaring
   task automatic test_saturation();
      set_view(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1, 10'd1);
      set_view(32'h8000_0000, 32'd0, 32'h8000_0000, 32'd0);   // largest magnitude
      send_pixel(10'd5, 10'd7);
      set_view(32'h0000_0001, 32'h0000_0001, 32'hffff_ffff, 32'hffff_ffff);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
   endtask

   // julia mode with constants at their extremes and inside the set
   task automatic test_julia();
      set_view(32'hf800_0000, 32'h0004_0000, 32'hf800_0000, 32'h0004_0000);
      set_julia(1'b1, 32'h7fff_ffff, 32'h8000_0000);
      send_pixel(10'd512, 10'd512);
      set_julia(1'b1, 32'h0000_0000, 32'h0000_0000);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd600, 10'd300);
      set_julia(1'b1, 32'hfcd7_0a3d, 32'h0099_999a);   // about -0.79 + 0.15i
      send_pixel(10'd500, 10'd520);
      send_pixel(10'd0, 10'd1023);
   endtask

   task automatic random_view();
      logic [31:0] x0, y0, dx, dy;
      case ($urandom_range(0, 4))
         0: begin
            x0 = $urandom; y0 = $urandom; dx = $urandom; dy = $urandom;
         end
         default: begin
            // a window near the set, steps kept small so pixels spread across it
            x0 = 32'hf800_0000 + $urandom_range(0, 32'h0400_0000);
            y0 = 32'hf800_0000 + $urandom_range(0, 32'h0400_0000);
            dx = $urandom_range(0, 32'h0008_0000);
            dy = $urandom_range(0, 32'h0008_0000);
            if ($urandom_range(0, 5) == 0) dx = -dx;
            if ($urandom_range(0, 5) == 0) dy = -dy;
         end
      endcase
      set_view(x0, dx, y0, dy);
   endtask

   task automatic test_random();
      logic [31:0] cr, ci;
      for (int phase = 0; phase < 12; phase++) begin
         random_view();
         cr = ($urandom_range(0, 3) == 0) ? $urandom
              : 32'hfc00_0000 + $urandom_range(0, 32'h0800_0000);
         ci = ($urandom_range(0, 3) == 0) ? $urandom
              : 32'hfc00_0000 + $urandom_range(0, 32'h0800_0000);
         set_julia(1'(phase % 2), cr, ci);
         for (int k = 0; k < 72; k++) begin
            send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
            idle_gap();
         end
      end
   endtask

   // receiver holds off while items keep coming, then sender waits for all
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      for (int k = 0; k < 6; k++)
         send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      drain();
      for (int k = 0; k < 4; k++)
         send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
   endtask

   // result side: random stalls, and one long hold when asked
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_rsp = 1'b0;
         end else if ($urandom_range(0, 40) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(10, 80);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // compare each accepted count with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_counts.size() == 0) begin
            $display("%0t: unexpected count %0d", $time, rsp_iteration_count);
            error_count++;
         end else begin
            if (rsp_iteration_count !== 9'(expected_counts[0])) begin
               $display("%0t: iteration_count expected %0d actual %0d",
                        $time, expected_counts[0], rsp_iteration_count);
               error_count++;
            end
            void'(expected_counts.pop_front());
         end
      end
   end

   initial begin
      view_x0 = 32'hf800_0000; view_dx = 32'h0004_0000;
      view_y0 = 32'hf800_0000; view_dy = 32'h0004_0000;
      jc_re = '0; jc_im = '0; mode_julia = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_mandel();
      test_saturation();
      test_julia();
      test_backpressure();
      test_random();
      drain();
      repeat (600) @(posedge clock);
      if (error_count == 0 && expected_counts.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // about 900 items, each running up to the iteration cap, with stalls, several times over
   initial begin
      #50_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/etf_pkg.sv
rtl/etf_sq_cell.sv
rtl/etf_acc_cell.sv
rtl/escape_time_fractal_pixel.sv
test/tb_escape_time_fractal_pixel.sv
